// ===== rtl/core/fpsqrt_pkg.sv =====
// Package for the fixed-point square root unit: root table and shared constants.
// Depends on nothing; used by fixed_point_square_root_unit.
`timescale 1ns / 1ps
`default_nettype none

package fpsqrt_pkg;

	typedef logic [20:0] rom_word_t;   // sqrt(i) in unsigned 5.16, i = 0..256
	typedef logic [7:0]  rom_idx_t;

	localparam int ROM_DEPTH = 257;

	// Inclusive range of operands that index the table by their integer part
	localparam logic [31:0] DIRECT_LO = 32'h0001_0000;
	localparam logic [31:0] DIRECT_HI = 32'h00FF_0000;

	// Half of the bit position at which the result needs no rescaling
	localparam logic signed [4:0] SHIFT_BIAS = 5'sd11;

	localparam rom_word_t ROOT_ROM [ROM_DEPTH] = '{
		21'h00000, 21'h10000, 21'h16A0A, 21'h1BB68, 21'h20000, 21'h23C6F, 21'h27312, 21'h2A550,
		21'h2D414, 21'h30000, 21'h3298B, 21'h3510E, 21'h376CF, 21'h39B05, 21'h3BDDD, 21'h3DF7C,
		21'h40000, 21'h41F84, 21'h43E1E, 21'h45BE1, 21'h478DE, 21'h49524, 21'h4B0BF, 21'h4CBBC,
		21'h4E624, 21'h50000, 21'h51959, 21'h53237, 21'h54AA0, 21'h5629A, 21'h57A2B, 21'h59159,
		21'h5A828, 21'h5BE9C, 21'h5D4B9, 21'h5EA84, 21'h60000, 21'h61530, 21'h62A17, 21'h63EB8,
		21'h65316, 21'h66733, 21'h67B12, 21'h68EB4, 21'h6A21D, 21'h6B54D, 21'h6C847, 21'h6DB0C,
		21'h6ED9F, 21'h70000, 21'h71232, 21'h72435, 21'h7360B, 21'h747B5, 21'h75935, 21'h76A8C,
		21'h77BBB, 21'h78CC2, 21'h79DA3, 21'h7AE60, 21'h7BEF8, 21'h7CF6D, 21'h7DFBF, 21'h7EFF0,
		21'h80000, 21'h80FF0, 21'h81FC1, 21'h82F73, 21'h83F08, 21'h84E7F, 21'h85DDA, 21'h86D18,
		21'h87C3B, 21'h88B44, 21'h89A32, 21'h8A906, 21'h8B7C2, 21'h8C664, 21'h8D4EE, 21'h8E361,
		21'h8F1BC, 21'h90000, 21'h90E2E, 21'h91C45, 21'h92A47, 21'h93834, 21'h9460C, 21'h953CF,
		21'h9617E, 21'h96F19, 21'h97CA1, 21'h98A16, 21'h99777, 21'h9A4C6, 21'h9B203, 21'h9BF2E,
		21'h9CC47, 21'h9D94F, 21'h9E645, 21'h9F32B, 21'hA0000, 21'hA0CC5, 21'hA1979, 21'hA261E,
		21'hA32B3, 21'hA3F38, 21'hA4BAE, 21'hA5816, 21'hA646E, 21'hA70B8, 21'hA7CF3, 21'hA8921,
		21'hA9540, 21'hAA151, 21'hAAD55, 21'hAB94B, 21'hAC534, 21'hAD110, 21'hADCDF, 21'hAE8A1,
		21'hAF457, 21'hB0000, 21'hB0B9D, 21'hB172D, 21'hB22B2, 21'hB2E2B, 21'hB3998, 21'hB44F9,
		21'hB504F, 21'hB5B9A, 21'hB66D9, 21'hB720E, 21'hB7D37, 21'hB8856, 21'hB936A, 21'hB9E74,
		21'hBA973, 21'hBB467, 21'hBBF52, 21'hBCA32, 21'hBD508, 21'hBDFD5, 21'hBEA98, 21'hBF551,
		21'hC0000, 21'hC0AA6, 21'hC1543, 21'hC1FD6, 21'hC2A60, 21'hC34E1, 21'hC3F59, 21'hC49C8,
		21'hC542E, 21'hC5E8C, 21'hC68E0, 21'hC732D, 21'hC7D70, 21'hC87AC, 21'hC91DF, 21'hC9C0A,
		21'hCA62C, 21'hCB047, 21'hCBA59, 21'hCC464, 21'hCCE66, 21'hCD861, 21'hCE254, 21'hCEC40,
		21'hCF624, 21'hD0000, 21'hD09D5, 21'hD13A2, 21'hD1D69, 21'hD2727, 21'hD30DF, 21'hD3A90,
		21'hD4439, 21'hD4DDC, 21'hD5777, 21'hD610C, 21'hD6A9A, 21'hD7421, 21'hD7DA1, 21'hD871B,
		21'hD908E, 21'hD99FA, 21'hDA360, 21'hDACBF, 21'hDB618, 21'hDBF6B, 21'hDC8B7, 21'hDD1FE,
		21'hDDB3D, 21'hDE477, 21'hDEDAB, 21'hDF6D8, 21'hE0000, 21'hE0922, 21'hE123D, 21'hE1B53,
		21'hE2463, 21'hE2D6D, 21'hE3672, 21'hE3F70, 21'hE4869, 21'hE515D, 21'hE5A4B, 21'hE6333,
		21'hE6C16, 21'hE74F3, 21'hE7DCB, 21'hE869D, 21'hE8F6B, 21'hE9832, 21'hEA0F5, 21'hEA9B2,
		21'hEB26B, 21'hEBB1E, 21'hEC3CB, 21'hECC74, 21'hED518, 21'hEDDB7, 21'hEE650, 21'hEEEE5,
		21'hEF775, 21'hF0000, 21'hF0886, 21'hF1107, 21'hF1984, 21'hF21FC, 21'hF2A6F, 21'hF32DD,
		21'hF3B47, 21'hF43AC, 21'hF4C0C, 21'hF5468, 21'hF5CBF, 21'hF6512, 21'hF6D60, 21'hF75AA,
		21'hF7DEF, 21'hF8630, 21'hF8E6D, 21'hF96A5, 21'hF9ED9, 21'hFA709, 21'hFAF34, 21'hFB75B,
		21'hFBF7E, 21'hFC79D, 21'hFCFB7, 21'hFD7CE, 21'hFDFE0, 21'hFE7EE, 21'hFEFF8, 21'hFF7FE,
		21'h100000
	};

endpackage

`default_nettype wire

// ===== rtl/core/fixed_point_square_root_unit.sv =====
// Fixed-point square root, signed 16.16 in, unsigned 8.16 out.
// done is registered and follows the accepted request through stages s1 to s5 and the output register.
// Throughput: one request per cycle, set by the six-stage pipeline; busy is always low.
// The receiver cannot stall, so nothing ever holds the pipeline.
// Reset clears all stage valid bits and done; data registers are not reset.
// Depends on fpsqrt_pkg for the root table and constants.
`timescale 1ns / 1ps
`default_nettype none

module fixed_point_square_root_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [31:0] operand,
	output logic                    done,
	output logic             [23:0] root
);

	import fpsqrt_pkg::*;

	// stage 1: captured operand
	logic              valid_s1;
	logic       [31:0] operand_s1;

	// stage 2: flags and half-word top-pair search
	logic              valid_s2;
	logic              zero_s2;
	logic              direct_s2;
	logic              hi_any_s2;
	logic       [2:0]  hi_idx_s2;
	logic       [2:0]  lo_idx_s2;
	logic       [30:0] v_s2;
	logic       [3:0]  w_s2;

	// stage 3: table index and rescale shift
	logic              valid_s3;
	logic              zero_s3;
	rom_idx_t          idx_s3;
	logic signed [4:0] sh_s3;
	logic       [3:0]  w_s3;

	// stage 4: neighbouring table entries
	logic              valid_s4;
	logic              zero_s4;
	rom_word_t         lo_s4;
	rom_word_t         hi_s4;
	logic signed [4:0] sh_s4;
	logic       [3:0]  w_s4;

	// stage 5: blended root before rescale
	logic              valid_s5;
	logic              zero_s5;
	rom_word_t         blend_s5;
	logic signed [4:0] sh_s5;

	logic              done_q;
	logic       [23:0] root_q;

	assign busy = 1'b0;
	assign done = done_q;
	assign root = root_q;

	// ---- stage 1 -> 2: even leading-bit search, split in two halves of eight pairs
	logic [15:0] pair_c;
	logic [2:0]  hi_idx_c;
	logic [2:0]  lo_idx_c;

	always_comb begin
		for (int k = 0; k < 16; k++) begin
			pair_c[k] = operand_s1[2*k] | operand_s1[2*k+1];
		end
		lo_idx_c = 3'd0;
		hi_idx_c = 3'd0;
		for (int k = 0; k < 8; k++) begin
			if (pair_c[k]) begin
				lo_idx_c = 3'(k);
			end
			if (pair_c[k+8]) begin
				hi_idx_c = 3'(k);
			end
		end
	end

	// ---- stage 2 -> 3: index and shift
	logic       [3:0]  k_c;
	logic       [4:0]  rsh_c;
	logic       [2:0]  lsh_c;
	logic       [30:0] shr_c;
	logic       [7:0]  shl_c;
	rom_idx_t          idx_c;
	logic signed [4:0] sh_c;

	always_comb begin
		k_c   = hi_any_s2 ? {1'b1, hi_idx_s2} : {1'b0, lo_idx_s2};
		rsh_c = {k_c, 1'b0} - 5'd6;
		lsh_c = 3'd6 - {k_c[1:0], 1'b0};
		shr_c = v_s2 >> rsh_c;
		shl_c = v_s2[7:0] << lsh_c;
		if (direct_s2) begin
			idx_c = v_s2[23:16];
			sh_c  = 5'sd0;
		end else begin
			// top pair at bit 8 or above normalises downwards, else upwards
			idx_c = (k_c >= 4'd4) ? shr_c[7:0] : shl_c;
			sh_c  = $signed({1'b0, k_c}) - SHIFT_BIAS;
		end
	end

	// ---- stage 4 -> 5: blend the two entries with 4-bit weights
	logic [4:0]  w_inv_c;
	logic [24:0] sum_c;

	always_comb begin
		w_inv_c = 5'd16 - {1'b0, w_s4};
		sum_c   = 25'(lo_s4) * 25'(w_inv_c) + 25'(hi_s4) * 25'(w_s4);
	end

	// ---- stage 5 -> out: rescale by a power of two
	logic [24:0] scaled_c;
	logic [4:0]  neg_sh_c;

	always_comb begin
		neg_sh_c = 5'(-sh_s5);
		if (sh_s5 > 5'sd0) begin
			scaled_c = {4'b0, blend_s5} << sh_s5[2:0];
		end else begin
			scaled_c = {4'b0, blend_s5} >> neg_sh_c[3:0];
		end
	end

	// ---- valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			done_q   <= valid_s5;
		end
	end

	// ---- data path; advance every cycle
	always_ff @(posedge clk) begin
		operand_s1 <= operand;

		zero_s2   <= operand_s1[31] || (operand_s1 == 32'd0);
		direct_s2 <= (operand_s1 >= DIRECT_LO) && (operand_s1 <= DIRECT_HI);
		hi_any_s2 <= |pair_c[15:8];
		hi_idx_s2 <= hi_idx_c;
		lo_idx_s2 <= lo_idx_c;
		v_s2      <= operand_s1[30:0];
		w_s2      <= operand_s1[15:12];

		zero_s3 <= zero_s2;
		idx_s3  <= idx_c;
		sh_s3   <= sh_c;
		w_s3    <= w_s2;

		zero_s4 <= zero_s3;
		lo_s4   <= ROOT_ROM[{1'b0, idx_s3}];
		hi_s4   <= ROOT_ROM[9'({1'b0, idx_s3} + 9'd1)];
		sh_s4   <= sh_s3;
		w_s4    <= w_s3;

		zero_s5  <= zero_s4;
		blend_s5 <= sum_c[24:4];
		sh_s5    <= sh_s4;

		root_q <= zero_s5 ? 24'd0 : scaled_c[23:0];
	end

	// ---- assertions
	a_done_follows_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 6))
		else $error("result strobe without a request six cycles earlier");

	a_nonpositive_gives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(operand[31] || (operand == 32'sd0), 6)) |-> (root == 24'd0))
		else $error("non-positive operand gave a nonzero root");

	a_direct_square: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(operand == 32'sh0004_0000, 6)) |-> (root == 24'h02_0000))
		else $error("root of 4.0 is not 2.0");

endmodule

`default_nettype wire
